FILE: hdl/fault_code_table_top_assert.svh
// Assertion macros for the fault code table
`ifndef FAULT_CODE_TABLE_TOP_ASSERT_SVH
`define FAULT_CODE_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FCT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/fct_pkg.sv
// Shared types, constants and function of the fault code table
`timescale 1ns / 1ps

package fct_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = 5;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] KIND_ADD       = 3'd0;
	localparam logic [2:0] KIND_REMOVE    = 3'd1;
	localparam logic [2:0] KIND_CLEAR     = 3'd2;
	localparam logic [2:0] KIND_QUERY     = 3'd3;
	localparam logic [2:0] KIND_READ_CONF = 3'd4;
	localparam logic [2:0] KIND_READ_PEND = 3'd5;
	localparam logic [2:0] KIND_SET_LAMP  = 3'd6;

	localparam logic [2:0] REG_CONFIRMED_MASK = 3'd0;
	localparam logic [2:0] REG_PENDING_MASK   = 3'd1;
	localparam logic [2:0] REG_POWERTRAIN     = 3'd2;
	localparam logic [2:0] REG_CHASSIS        = 3'd3;
	localparam logic [2:0] REG_BODY           = 3'd4;
	localparam logic [2:0] REG_NETWORK        = 3'd5;

	localparam logic [7:0] CONFIRMED_MASK_RST = 8'h08;
	localparam logic [7:0] PENDING_MASK_RST   = 8'h04;
	localparam logic [7:0] POWERTRAIN_RST     = 8'd80;
	localparam logic [7:0] CHASSIS_RST        = 8'd67;
	localparam logic [7:0] BODY_RST           = 8'd66;
	localparam logic [7:0] NETWORK_RST        = 8'd85;

	localparam logic [1:0] PFX_POWERTRAIN = 2'b00;
	localparam logic [1:0] PFX_CHASSIS    = 2'b01;
	localparam logic [1:0] PFX_BODY       = 2'b10;
	localparam logic [1:0] PFX_NETWORK    = 2'b11;

	typedef struct packed {
		logic [7:0] confirmed_mask;
		logic [7:0] pending_mask;
		logic [7:0] powertrain_letter;
		logic [7:0] chassis_letter;
		logic [7:0] body_letter;
		logic [7:0] network_letter;
	} cfg_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_SINGLE,
		EMIT_EMPTY,
		EMIT_COUNT,
		EMIT_HI,
		EMIT_LO
	} emit_sel_t;

	typedef struct packed {
		logic      take;
		logic      step;
		logic      rewind;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [2:0] kind;
		logic       out_free;
		logic       at_end;
		logic       entry_hit;
		logic       limit_zero;
		logic       no_pairs;
		logic       pair_last;
	} status_t;

	typedef struct packed {
		logic             success;
		logic [7:0]       entry_status;
		logic [CNT_W-1:0] entry_count;
		logic             lamp;
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic             last;
	} res_t;

	function automatic logic [1:0] type_prefix(input logic [7:0] t, input cfg_t c);
		logic [1:0] p;
		if (t == c.powertrain_letter) p = PFX_POWERTRAIN;
		else if (t == c.chassis_letter) p = PFX_CHASSIS;
		else if (t == c.body_letter) p = PFX_BODY;
		else if (t == c.network_letter) p = PFX_NETWORK;
		else p = PFX_POWERTRAIN;
		return p;
	endfunction

endpackage

FILE: hdl/fct_if.sv
// Command and result channel interfaces of the fault code table
`timescale 1ns / 1ps

interface fct_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [15:0] fault_code;
	logic [7:0] type_byte;
	logic [7:0] status_in;
	logic [7:0] byte_limit;
	logic       lamp_value;

	modport source (output valid, kind, fault_code, type_byte, status_in, byte_limit,
		lamp_value, input ready);
	modport sink (input valid, kind, fault_code, type_byte, status_in, byte_limit,
		lamp_value, output ready);
endinterface

interface fct_out_if;
	logic                      valid;
	logic                      ready;
	logic                      success;
	logic [7:0]                entry_status;
	logic [fct_pkg::CNT_W-1:0] entry_count;
	logic                      lamp;
	logic [7:0]                out_byte;
	logic                      byte_valid;
	logic                      last;

	modport source (output valid, success, entry_status, entry_count, lamp, out_byte,
		byte_valid, last, input ready);
	modport sink (input valid, success, entry_status, entry_count, lamp, out_byte,
		byte_valid, last, output ready);
endinterface

FILE: hdl/fct_regs.sv
// APB configuration registers of the fault code table
`timescale 1ns / 1ps

module fct_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fct_pkg::ADDR_W-1:0] paddr,
	input  logic [fct_pkg::DATA_W-1:0] pwdata,
	output logic [fct_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output fct_pkg::cfg_t              cfg
);

	fct_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[fct_pkg::ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirmed_mask    <= fct_pkg::CONFIRMED_MASK_RST;
			cfg_q.pending_mask      <= fct_pkg::PENDING_MASK_RST;
			cfg_q.powertrain_letter <= fct_pkg::POWERTRAIN_RST;
			cfg_q.chassis_letter    <= fct_pkg::CHASSIS_RST;
			cfg_q.body_letter       <= fct_pkg::BODY_RST;
			cfg_q.network_letter    <= fct_pkg::NETWORK_RST;
		end else if (wr_en) begin
			case (reg_idx)
				fct_pkg::REG_CONFIRMED_MASK: cfg_q.confirmed_mask    <= pwdata[7:0];
				fct_pkg::REG_PENDING_MASK:   cfg_q.pending_mask      <= pwdata[7:0];
				fct_pkg::REG_POWERTRAIN:     cfg_q.powertrain_letter <= pwdata[7:0];
				fct_pkg::REG_CHASSIS:        cfg_q.chassis_letter    <= pwdata[7:0];
				fct_pkg::REG_BODY:           cfg_q.body_letter       <= pwdata[7:0];
				fct_pkg::REG_NETWORK:        cfg_q.network_letter    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fct_pkg::REG_CONFIRMED_MASK: prdata = {24'd0, cfg_q.confirmed_mask};
			fct_pkg::REG_PENDING_MASK:   prdata = {24'd0, cfg_q.pending_mask};
			fct_pkg::REG_POWERTRAIN:     prdata = {24'd0, cfg_q.powertrain_letter};
			fct_pkg::REG_CHASSIS:        prdata = {24'd0, cfg_q.chassis_letter};
			fct_pkg::REG_BODY:           prdata = {24'd0, cfg_q.body_letter};
			fct_pkg::REG_NETWORK:        prdata = {24'd0, cfg_q.network_letter};
			default:                     prdata = '0;
		endcase
	end

endmodule

FILE: hdl/fct_ctrl.sv
// Controller state machine of the fault code table
`timescale 1ns / 1ps

module fct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  fct_pkg::status_t status,
	output fct_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCAN    = 7'b0000010,
		ST_RESULT  = 7'b0000100,
		ST_COUNT   = 7'b0001000,
		ST_CNT_OUT = 7'b0010000,
		ST_LIST    = 7'b0100000,
		ST_LO_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.take     = 1'b0;
		cmd.step     = 1'b0;
		cmd.rewind   = 1'b0;
		cmd.emit_sel = fct_pkg::EMIT_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (status.in_valid) begin
					case (status.kind)
						fct_pkg::KIND_ADD,
						fct_pkg::KIND_REMOVE,
						fct_pkg::KIND_QUERY:     state_d = ST_SCAN;
						fct_pkg::KIND_READ_CONF,
						fct_pkg::KIND_READ_PEND: state_d = ST_COUNT;
						default:                 state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.at_end) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.emit_sel = fct_pkg::EMIT_SINGLE;
					state_d      = ST_IDLE;
				end
			end
			ST_COUNT: begin
				cmd.step = 1'b1;
				if (status.at_end) state_d = ST_CNT_OUT;
			end
			ST_CNT_OUT: begin
				if (status.out_free) begin
					if (status.limit_zero) begin
						cmd.emit_sel = fct_pkg::EMIT_EMPTY;
						state_d      = ST_IDLE;
					end else begin
						cmd.emit_sel = fct_pkg::EMIT_COUNT;
						cmd.rewind   = 1'b1;
						state_d      = status.no_pairs ? ST_IDLE : ST_LIST;
					end
				end
			end
			ST_LIST: begin
				if (status.entry_hit) begin
					if (status.out_free) begin
						cmd.emit_sel = fct_pkg::EMIT_HI;
						state_d      = ST_LO_OUT;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_LO_OUT: begin
				if (status.out_free) begin
					cmd.emit_sel = fct_pkg::EMIT_LO;
					cmd.step     = 1'b1;
					state_d      = status.pair_last ? ST_IDLE : ST_LIST;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/fct_dp.sv
// Datapath of the fault code table: entry store, scan index and result register
`timescale 1ns / 1ps

module fct_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  fct_pkg::cfg_t    cfg,
	input  fct_pkg::cmd_t    cmd,
	output fct_pkg::status_t status,
	fct_in_if.sink           req,
	fct_out_if.source        rsp
);

	localparam int DEPTH = fct_pkg::TABLE_DEPTH;
	localparam int IDX_W = fct_pkg::IDX_W;
	localparam int CNT_W = fct_pkg::CNT_W;

	// latched command
	logic [2:0]  kind_q;
	logic [15:0] code_q;
	logic [7:0]  type_q;
	logic [7:0]  stat_q;
	logic [7:0]  limit_q;
	logic        lamp_in_q;

	// entry store
	logic [DEPTH-1:0] entry_valid_q;
	logic [15:0]      entry_code_q [DEPTH];
	logic [7:0]       entry_type_q [DEPTH];
	logic [7:0]       entry_bits_q [DEPTH];
	logic [CNT_W-1:0] valid_count_q;
	logic             lamp_q;

	// scan state
	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic             free_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [7:0]       found_bits_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] pairs_q;

	fct_pkg::res_t    res_q, res_d;
	logic             rsp_valid_q;

	logic             accept;
	logic             commit;
	logic             cur_valid;
	logic [15:0]      cur_code;
	logic [7:0]       cur_type;
	logic [7:0]       cur_bits;
	logic [7:0]       mask;
	logic             key_hit;
	logic             entry_hit;
	logic [7:0]       limit_m1;
	logic [6:0]       half;
	logic [CNT_W-1:0] pairs_new;
	logic             ok;
	logic [7:0]       st;
	logic [CNT_W-1:0] cnt_nx;
	logic             lamp_nx;

	assign req.ready = cmd.take;
	assign accept    = cmd.take & req.valid;
	assign commit    = (cmd.emit_sel == fct_pkg::EMIT_SINGLE);

	assign cur_valid = entry_valid_q[idx_q];
	assign cur_code  = entry_code_q[idx_q];
	assign cur_type  = entry_type_q[idx_q];
	assign cur_bits  = entry_bits_q[idx_q];
	assign mask      = (kind_q == fct_pkg::KIND_READ_CONF) ? cfg.confirmed_mask
		: cfg.pending_mask;
	assign key_hit   = cur_valid && (cur_code == code_q) && (cur_type == type_q);
	assign entry_hit = cur_valid && ((cur_bits & mask) != 8'd0);

	// code pairs that fit after the count byte
	assign limit_m1  = limit_q - 8'd1;
	assign half      = limit_m1[7:1];
	assign pairs_new = (7'(hit_cnt_q) < half) ? hit_cnt_q : CNT_W'(half);

	assign status.in_valid   = req.valid;
	assign status.kind       = req.kind;
	assign status.out_free   = !rsp_valid_q || rsp.ready;
	assign status.at_end     = (idx_q == IDX_W'(DEPTH - 1));
	assign status.entry_hit  = entry_hit;
	assign status.limit_zero = (limit_q == 8'd0);
	assign status.no_pairs   = (pairs_new == '0);
	assign status.pair_last  = (pairs_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			code_q    <= req.fault_code;
			type_q    <= req.type_byte;
			stat_q    <= req.status_in;
			limit_q   <= req.byte_limit;
			lamp_in_q <= req.lamp_value;
		end
	end

	always_comb begin
		ok      = 1'b0;
		st      = 8'd0;
		cnt_nx  = valid_count_q;
		lamp_nx = lamp_q;
		case (kind_q)
			fct_pkg::KIND_ADD: begin
				if (found_q) begin
					ok = 1'b1;
				end else if (free_q) begin
					ok     = 1'b1;
					cnt_nx = valid_count_q + CNT_W'(1);
					if ((stat_q & cfg.confirmed_mask) != 8'd0) lamp_nx = 1'b1;
				end
			end
			fct_pkg::KIND_REMOVE: begin
				if (found_q) begin
					ok = 1'b1;
					if (valid_count_q != '0) cnt_nx = valid_count_q - CNT_W'(1);
					if (cnt_nx == '0) lamp_nx = 1'b0;
				end
			end
			fct_pkg::KIND_CLEAR: begin
				ok      = 1'b1;
				cnt_nx  = '0;
				lamp_nx = 1'b0;
			end
			fct_pkg::KIND_QUERY: begin
				ok = found_q;
				st = found_q ? found_bits_q : 8'd0;
			end
			fct_pkg::KIND_READ_CONF,
			fct_pkg::KIND_READ_PEND: ok = 1'b1;
			fct_pkg::KIND_SET_LAMP: begin
				ok      = 1'b1;
				lamp_nx = lamp_in_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit && (kind_q == fct_pkg::KIND_ADD)) begin
			if (found_q) begin
				entry_bits_q[match_idx_q] <= found_bits_q | stat_q;
			end else if (free_q) begin
				entry_code_q[free_idx_q] <= code_q;
				entry_type_q[free_idx_q] <= type_q;
				entry_bits_q[free_idx_q] <= stat_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			valid_count_q <= '0;
			lamp_q        <= 1'b0;
		end else if (commit) begin
			valid_count_q <= cnt_nx;
			lamp_q        <= lamp_nx;
			case (kind_q)
				fct_pkg::KIND_ADD: begin
					if (!found_q && free_q) entry_valid_q[free_idx_q] <= 1'b1;
				end
				fct_pkg::KIND_REMOVE: begin
					if (found_q) entry_valid_q[match_idx_q] <= 1'b0;
				end
				fct_pkg::KIND_CLEAR: entry_valid_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			match_idx_q  <= '0;
			free_idx_q   <= '0;
			found_bits_q <= 8'd0;
			hit_cnt_q    <= '0;
			pairs_q      <= '0;
		end else if (accept) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			hit_cnt_q <= '0;
		end else begin
			if (cmd.rewind) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.step) begin
				if (key_hit && !found_q) begin
					found_q      <= 1'b1;
					match_idx_q  <= idx_q;
					found_bits_q <= cur_bits;
				end
				if (!cur_valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
				if (entry_hit) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
			if (cmd.emit_sel == fct_pkg::EMIT_COUNT) begin
				pairs_q <= pairs_new;
			end else if (cmd.emit_sel == fct_pkg::EMIT_LO) begin
				pairs_q <= pairs_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		res_d              = res_q;
		res_d.success      = 1'b1;
		res_d.entry_status = 8'd0;
		res_d.entry_count  = valid_count_q;
		res_d.lamp         = lamp_q;
		res_d.out_byte     = 8'd0;
		res_d.byte_valid   = 1'b0;
		res_d.last         = 1'b1;
		case (cmd.emit_sel)
			fct_pkg::EMIT_SINGLE: begin
				res_d.success      = ok;
				res_d.entry_status = st;
				res_d.entry_count  = cnt_nx;
				res_d.lamp         = lamp_nx;
			end
			fct_pkg::EMIT_EMPTY: ;
			fct_pkg::EMIT_COUNT: begin
				res_d.out_byte   = 8'(hit_cnt_q);
				res_d.byte_valid = 1'b1;
				res_d.last       = status.no_pairs;
			end
			fct_pkg::EMIT_HI: begin
				res_d.out_byte   = {fct_pkg::type_prefix(cur_type, cfg), cur_code[13:8]};
				res_d.byte_valid = 1'b1;
				res_d.last       = 1'b0;
			end
			fct_pkg::EMIT_LO: begin
				res_d.out_byte   = cur_code[7:0];
				res_d.byte_valid = 1'b1;
				res_d.last       = status.pair_last;
			end
			default: res_d = res_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sel != fct_pkg::EMIT_NONE) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_sel != fct_pkg::EMIT_NONE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.success      = res_q.success;
	assign rsp.entry_status = res_q.entry_status;
	assign rsp.entry_count  = res_q.entry_count;
	assign rsp.lamp         = res_q.lamp;
	assign rsp.out_byte     = res_q.out_byte;
	assign rsp.byte_valid   = res_q.byte_valid;
	assign rsp.last         = res_q.last;

endmodule

FILE: hdl/fault_code_table_top.sv
// Top level of the fault code table
`timescale 1ns / 1ps
// Fault code table: a 16-entry store of fault codes keyed by code and type letter.
// req carries one command per transfer (add, remove, clear, query, set lamp, or a
// confirmed or pending readout). rsp carries the results; last marks the final one.
// Non-readout commands give one result; readouts give a count byte and then two
// bytes per listed code, capped by byte_limit, or one byteless result when
// byte_limit is zero. Add, remove and query scan the table one entry a cycle over
// the single entry read port. A readout counts the hits in one full scan, then
// rescans the table and sends the high and low byte of each listed code in turn.
// A new command is taken only after the previous one has its last result in the
// output register; that register may still be waiting.
// When rsp.ready is low the result register holds and the next result waits for it.
// Reset clears all entries, the count and the lamp, and loads the register
// defaults; the block is ready as soon as reset is released.
// The APB port holds six 8-bit registers at byte addresses 0 to 20.

`include "fault_code_table_top_assert.svh"

module fault_code_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	fct_in_if.sink                            req,
	fct_out_if.source                         rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fct_pkg::ADDR_W-1:0]        paddr,
	input  logic [fct_pkg::DATA_W-1:0]        pwdata,
	output logic [fct_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	fct_pkg::cfg_t    cfg;
	fct_pkg::cmd_t    cmd;
	fct_pkg::status_t status;

	fct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	fct_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.req    (req),
		.rsp    (rsp)
	);

	`FCT_ASSERT_NEXT(a_one_cmd_at_a_time, req.valid && req.ready, !req.ready, "command taken while busy")
	`FCT_ASSERT_NOW(a_no_byte_is_last, rsp.valid && !rsp.byte_valid, rsp.last, "byteless result not last")
	`FCT_ASSERT_NOW(a_count_in_range, rsp.valid, rsp.entry_count <= fct_pkg::CNT_W'(fct_pkg::TABLE_DEPTH), "entry count over depth")

endmodule

FILE: tb/sv/testbench.sv
// Testbench for fault_code_table_top: directed and random command traffic checked against a table model
`timescale 1ns / 1ps

module testbench;
	import fct_pkg::*;

	localparam logic [2:0] KIND_UNDEF = 3'd7;
	localparam int POOL_SIZE = 24;
	localparam int PHASE_ITEMS = 62;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] code;
		logic [7:0]  key_type;
		logic [7:0]  status;
		logic [7:0]  limit;
		logic        lamp_v;
	} dtc_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fct_in_if  req_if();
	fct_out_if rsp_if();

	fault_code_table_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cfg_t             cfg_shadow;
	logic             slot_valid [TABLE_DEPTH];
	logic [15:0]      slot_code [TABLE_DEPTH];
	logic [7:0]       slot_type [TABLE_DEPTH];
	logic [7:0]       slot_bits [TABLE_DEPTH];
	logic [CNT_W-1:0] fill_count;
	logic             lamp_on;

	res_t     due_rsp [$];
	dtc_cmd_t cmd_queue [$];
	dtc_cmd_t next_cmd;
	logic [15:0] pool_code [POOL_SIZE];
	logic [7:0]  pool_type [POOL_SIZE];

	int   fail_count;
	int   idle_cycles;
	int   burst_left;
	int   gap_left;
	int   ready_run;
	logic in_took;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dtc_cmd_t mk_cmd(input logic [2:0] kind, input logic [15:0] code,
		input logic [7:0] key_type, input logic [7:0] status, input logic [7:0] limit,
		input logic lamp_v);
		dtc_cmd_t c;
		c.kind = kind;
		c.code = code;
		c.key_type = key_type;
		c.status = status;
		c.limit = limit;
		c.lamp_v = lamp_v;
		return c;
	endfunction

	function automatic int find_slot(input logic [15:0] code, input logic [7:0] key_type);
		int hit;
		hit = -1;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--)
			if (slot_valid[i] && slot_code[i] == code && slot_type[i] == key_type)
				hit = i;
		return hit;
	endfunction

	function automatic res_t make_res(input logic ok, input logic [7:0] st,
		input logic [7:0] data, input logic bv, input logic fin);
		res_t r;
		r.success = ok;
		r.entry_status = st;
		r.entry_count = fill_count;
		r.lamp = lamp_on;
		r.out_byte = data;
		r.byte_valid = bv;
		r.last = fin;
		return r;
	endfunction

	// Updates the table model and queues the results one command produces
	task automatic apply_dtc_command(input dtc_cmd_t c);
		logic       ok;
		logic [7:0] st;
		logic [7:0] mask;
		logic [7:0] hits;
		logic [1:0] pfx;
		logic [7:0] readout [$];
		int         slot;
		int         pos;
		ok = 1'b0;
		st = 8'h00;
		if (c.kind == KIND_READ_CONF || c.kind == KIND_READ_PEND) begin
			mask = (c.kind == KIND_READ_CONF) ? cfg_shadow.confirmed_mask
				: cfg_shadow.pending_mask;
			hits = 8'd0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (slot_valid[i] && (slot_bits[i] & mask) != 8'h00)
					hits++;
			pos = 0;
			if (c.limit >= 8'd1) begin
				readout.push_back(hits);
				pos = 1;
			end
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (pos + 1 < c.limit && slot_valid[i] && (slot_bits[i] & mask) != 8'h00) begin
					// first letter match wins, unknown letters map to powertrain
					if (slot_type[i] == cfg_shadow.powertrain_letter) pfx = PFX_POWERTRAIN;
					else if (slot_type[i] == cfg_shadow.chassis_letter) pfx = PFX_CHASSIS;
					else if (slot_type[i] == cfg_shadow.body_letter) pfx = PFX_BODY;
					else if (slot_type[i] == cfg_shadow.network_letter) pfx = PFX_NETWORK;
					else pfx = PFX_POWERTRAIN;
					readout.push_back({pfx, slot_code[i][13:8]});
					readout.push_back(slot_code[i][7:0]);
					pos += 2;
				end
			end
			if (readout.size() == 0)
				due_rsp.push_back(make_res(1'b1, 8'h00, 8'h00, 1'b0, 1'b1));
			for (int k = 0; k < readout.size(); k++)
				due_rsp.push_back(make_res(1'b1, 8'h00, readout[k], 1'b1,
					k == readout.size() - 1));
		end else begin
			case (c.kind)
				KIND_ADD: begin
					slot = find_slot(c.code, c.key_type);
					if (slot >= 0) begin
						slot_bits[slot] = slot_bits[slot] | c.status;
						ok = 1'b1;
					end else begin
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							if (!ok && !slot_valid[i]) begin
								slot_valid[i] = 1'b1;
								slot_code[i] = c.code;
								slot_type[i] = c.key_type;
								slot_bits[i] = c.status;
								fill_count++;
								if ((c.status & cfg_shadow.confirmed_mask) != 8'h00)
									lamp_on = 1'b1;
								ok = 1'b1;
							end
						end
					end
				end
				KIND_REMOVE: begin
					slot = find_slot(c.code, c.key_type);
					if (slot >= 0) begin
						slot_valid[slot] = 1'b0;
						if (fill_count > 0)
							fill_count--;
						if (fill_count == 0)
							lamp_on = 1'b0;
						ok = 1'b1;
					end
				end
				KIND_CLEAR: begin
					for (int i = 0; i < TABLE_DEPTH; i++)
						slot_valid[i] = 1'b0;
					fill_count = '0;
					lamp_on = 1'b0;
					ok = 1'b1;
				end
				KIND_QUERY: begin
					slot = find_slot(c.code, c.key_type);
					if (slot >= 0) begin
						ok = 1'b1;
						st = slot_bits[slot];
					end
				end
				KIND_SET_LAMP: begin
					lamp_on = c.lamp_v;
					ok = 1'b1;
				end
				default: ;
			endcase
			due_rsp.push_back(make_res(ok, st, 8'h00, 1'b0, 1'b1));
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic apb_write(input logic [2:0] idx, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CONFIRMED_MASK: cfg_shadow.confirmed_mask = value;
			REG_PENDING_MASK:   cfg_shadow.pending_mask = value;
			REG_POWERTRAIN:     cfg_shadow.powertrain_letter = value;
			REG_CHASSIS:        cfg_shadow.chassis_letter = value;
			REG_BODY:           cfg_shadow.body_letter = value;
			REG_NETWORK:        cfg_shadow.network_letter = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] conf, input logic [7:0] pend,
		input logic [7:0] pt, input logic [7:0] ch, input logic [7:0] bo, input logic [7:0] nw);
		apb_write(REG_CONFIRMED_MASK, conf);
		apb_write(REG_PENDING_MASK, pend);
		apb_write(REG_POWERTRAIN, pt);
		apb_write(REG_CHASSIS, ch);
		apb_write(REG_BODY, bo);
		apb_write(REG_NETWORK, nw);
	endtask

	function automatic dtc_cmd_t rand_cmd();
		int         j;
		int         pick;
		logic [2:0] kind;
		logic [7:0] limit;
		j = $urandom_range(0, POOL_SIZE - 1);
		pick = $urandom_range(0, 99);
		if (pick < 35) kind = KIND_ADD;
		else if (pick < 50) kind = KIND_REMOVE;
		else if (pick < 65) kind = KIND_QUERY;
		else if (pick < 75) kind = KIND_READ_CONF;
		else if (pick < 85) kind = KIND_READ_PEND;
		else if (pick < 91) kind = KIND_SET_LAMP;
		else if (pick < 96) kind = KIND_CLEAR;
		else kind = KIND_UNDEF;
		pick = $urandom_range(0, 9);
		if (pick < 5) limit = 8'($urandom_range(0, 8));
		else if (pick < 8) limit = 8'($urandom_range(9, 40));
		else limit = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) == 0)
			return mk_cmd(kind, 16'($urandom), 8'($urandom), 8'($urandom), limit,
				1'($urandom));
		return mk_cmd(kind, pool_code[j], pool_type[j], 8'($urandom), limit, 1'($urandom));
	endfunction

	// Mostly keys from a small pool so adds merge and removes hit; bursts fill and empty it
	task automatic queue_random_items(input int n);
		int k;
		int sel;
		for (int j = 0; j < POOL_SIZE; j++) begin
			pool_code[j] = 16'($urandom);
			case ($urandom_range(0, 5))
				0: pool_type[j] = cfg_shadow.powertrain_letter;
				1: pool_type[j] = cfg_shadow.chassis_letter;
				2: pool_type[j] = cfg_shadow.body_letter;
				3: pool_type[j] = cfg_shadow.network_letter;
				default: pool_type[j] = 8'($urandom);
			endcase
		end
		k = 0;
		while (k < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				for (int j = 0; j < POOL_SIZE; j++)
					cmd_queue.push_back(mk_cmd(KIND_ADD, pool_code[j], pool_type[j],
						8'($urandom), 8'($urandom), 1'($urandom)));
				k += POOL_SIZE;
			end else if (sel < 5) begin
				for (int j = 0; j < POOL_SIZE; j++)
					cmd_queue.push_back(mk_cmd(KIND_REMOVE, pool_code[j], pool_type[j],
						8'($urandom), 8'($urandom), 1'($urandom)));
				k += POOL_SIZE;
			end else begin
				cmd_queue.push_back(rand_cmd());
				k++;
			end
		end
	endtask

	// sampled at the rising edge, where the sender's outputs have settled
	task automatic wait_for_idle();
		while (cmd_queue.size() != 0 || req_if.valid || due_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// command sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!req_if.valid || in_took)) begin
			if (gap_left > 0 || cmd_queue.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				req_if.valid <= 1'b0;
			end else begin
				next_cmd = cmd_queue.pop_front();
				req_if.valid <= 1'b1;
				req_if.kind <= next_cmd.kind;
				req_if.fault_code <= next_cmd.code;
				req_if.type_byte <= next_cmd.key_type;
				req_if.status_in <= next_cmd.status;
				req_if.byte_limit <= next_cmd.limit;
				req_if.lamp_value <= next_cmd.lamp_v;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// result receiver: short stalls between ready runs, some of them long
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_run > 0) begin
				ready_run--;
			end else if (rsp_if.ready) begin
				rsp_if.ready <= 1'b0;
				ready_run = $urandom_range(0, 4);
			end else begin
				rsp_if.ready <= 1'b1;
				ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
					: $urandom_range(0, 9);
			end
		end
	end

	// result check comes before prediction: a command's results never share its transfer edge
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= req_if.valid && req_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				if (due_rsp.size() == 0) begin
					$error("result transfer with no result outstanding");
					fail_count++;
				end else begin
					want = due_rsp.pop_front();
					check_field("success", 8'(want.success), 8'(rsp_if.success));
					check_field("entry_status", want.entry_status, rsp_if.entry_status);
					check_field("entry_count", 8'(want.entry_count), 8'(rsp_if.entry_count));
					check_field("lamp", 8'(want.lamp), 8'(rsp_if.lamp));
					check_field("out_byte", want.out_byte, rsp_if.out_byte);
					check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_if.byte_valid));
					check_field("last", 8'(want.last), 8'(rsp_if.last));
				end
			end
			if (req_if.valid && req_if.ready)
				apply_dtc_command(mk_cmd(req_if.kind, req_if.fault_code, req_if.type_byte,
					req_if.status_in, req_if.byte_limit, req_if.lamp_value));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
			|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("fault_code_table_top test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_ADD;
		req_if.fault_code = 16'h0000;
		req_if.type_byte = 8'h00;
		req_if.status_in = 8'h00;
		req_if.byte_limit = 8'h00;
		req_if.lamp_value = 1'b0;
		rsp_if.ready = 1'b0;
		in_took = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		burst_left = 1;
		gap_left = 0;
		ready_run = 0;
		cfg_shadow.confirmed_mask = CONFIRMED_MASK_RST;
		cfg_shadow.pending_mask = PENDING_MASK_RST;
		cfg_shadow.powertrain_letter = POWERTRAIN_RST;
		cfg_shadow.chassis_letter = CHASSIS_RST;
		cfg_shadow.body_letter = BODY_RST;
		cfg_shadow.network_letter = NETWORK_RST;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_valid[i] = 1'b0;
			slot_code[i] = 16'h0000;
			slot_type[i] = 8'h00;
			slot_bits[i] = 8'h00;
		end
		fill_count = '0;
		lamp_on = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// misses on an empty table, empty readouts
		cmd_queue.push_back(mk_cmd(KIND_QUERY, 16'h1234, POWERTRAIN_RST, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_REMOVE, 16'h1234, POWERTRAIN_RST, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_READ_CONF, 16'h0000, 8'h00, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_READ_PEND, 16'h0000, 8'h00, 8'h00, 8'd255, 1'b0));
		// one key per letter plus unknown letters, code extremes
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'h0000, POWERTRAIN_RST, 8'h04, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'hFFFF, CHASSIS_RST, 8'h08, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'h3FFF, BODY_RST, 8'h0C, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'hC001, NETWORK_RST, 8'hFF, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'hABCD, 8'h00, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'h5555, 8'hFF, 8'h80, 8'd0, 1'b0));
		// merge into an existing key, then query hit and same code other letter
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'hFFFF, CHASSIS_RST, 8'h04, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_QUERY, 16'hFFFF, CHASSIS_RST, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_QUERY, 16'hFFFF, BODY_RST, 8'h00, 8'd0, 1'b0));
		// readouts: full, truncated to a pair, count only
		cmd_queue.push_back(mk_cmd(KIND_READ_CONF, 16'h0000, 8'h00, 8'h00, 8'd255, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_READ_PEND, 16'h0000, 8'h00, 8'h00, 8'd4, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_READ_PEND, 16'h0000, 8'h00, 8'h00, 8'd2, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_READ_CONF, 16'h0000, 8'h00, 8'h00, 8'd1, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_SET_LAMP, 16'h0000, 8'h00, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_UNDEF, 16'hFFFF, 8'hFF, 8'hFF, 8'd255, 1'b1));
		cmd_queue.push_back(mk_cmd(KIND_SET_LAMP, 16'h0000, 8'h00, 8'h00, 8'd0, 1'b1));
		cmd_queue.push_back(mk_cmd(KIND_REMOVE, 16'h0000, POWERTRAIN_RST, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_CLEAR, 16'h0000, 8'h00, 8'h00, 8'd0, 1'b0));
		// lamp goes off when the last entry leaves
		cmd_queue.push_back(mk_cmd(KIND_ADD, 16'h2AAA, NETWORK_RST, 8'h08, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_REMOVE, 16'h2AAA, NETWORK_RST, 8'h00, 8'd0, 1'b0));
		cmd_queue.push_back(mk_cmd(KIND_QUERY, 16'h2AAA, NETWORK_RST, 8'h00, 8'd0, 1'b0));
		queue_random_items(PHASE_ITEMS);
		wait_for_idle();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: set_config(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F);
				// duplicate letters: first match wins
				2: set_config(8'h00, 8'hFF, 8'h43, 8'h43, 8'h55, 8'h55);
				3: set_config(8'h01, 8'h80, POWERTRAIN_RST, CHASSIS_RST, BODY_RST, NETWORK_RST);
				default: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			endcase
			queue_random_items(PHASE_ITEMS);
			wait_for_idle();
		end

		if (fail_count == 0)
			$display("fault_code_table_top test passed");
		else
			$display("fault_code_table_top test failed");
		$finish;
	end

endmodule
